@@ hw/rtl/ufws_pkg.sv @@
// Package with the field widths, limits and operation codes of the weighted union-find unit.
package ufws_pkg;

  localparam int NODE_COUNT_DEF = 1024;

  localparam int MODE_W   = 2;
  localparam int NODE_W   = 10;
  localparam int RANK_W   = 4;
  localparam int WEIGHT_W = 11;

  localparam logic [RANK_W-1:0]   RANK_MAX   = 4'd15;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 11'd2047;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_UNION = 2'd1,
    MODE_FIND  = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

endpackage

@@ hw/rtl/union_find_weighted_sets.sv @@
// Top level of the weighted union-find unit: sequencer, node memory and result register.
//
// The unit keeps a forest of NODE_COUNT nodes in one memory word per node (parent, rank,
// weight). An input transfer carries a mode, two node indexes and a weight flag: load
// sets the weight of a singleton node, union merges the sets of two nodes by rank, find
// returns a node's root and compresses the path to it. Every input transfer yields
// exactly one output transfer with the root, the set weight and a merged flag.
// The sequencer drives the memory's read port and write port, at most one access each per
// cycle. A find walks up to the root and then points each node on the path at it; the
// spare mode code does the same, and so does a load on a node that is not a singleton,
// while a load on a singleton stores its flag at once. A union finds both roots and,
// when two sets merge, writes the loser and then the winner. An index out of range goes
// straight to the result. With union by rank the trees stay shallow.
// in_stall is low only while the sequencer is idle; one finished result waits in the
// output register, so a new item is accepted while the receiver still stalls it, and
// that item then holds in its last state until the output register is free.
// After rst_n is released the unit clears the node memory, one node per cycle, through
// all NODE_COUNT nodes; in_stall stays high during that sweep.
module union_find_weighted_sets_unit #(
  parameter int NODE_COUNT = ufws_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ufws_pkg::MODE_W-1:0]   in_mode,
  input  logic [ufws_pkg::NODE_W-1:0]   in_node_a,
  input  logic [ufws_pkg::NODE_W-1:0]   in_node_b,
  input  logic                          in_weight_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ufws_pkg::NODE_W-1:0]   out_root,
  output logic [ufws_pkg::WEIGHT_W-1:0] out_set_weight,
  output logic                          out_merged
);

  localparam int IW     = $clog2(NODE_COUNT);
  localparam int NW     = ufws_pkg::NODE_W;
  localparam int RW     = ufws_pkg::RANK_W;
  localparam int WW     = ufws_pkg::WEIGHT_W;
  localparam int WORD_W = IW + RW + WW;
  localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LDCHK  = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_COMP   = 9'b000010000,
    S_FDONE  = 9'b000100000,
    S_MERGE1 = 9'b001000000,
    S_MERGE2 = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  // Node memory.
  logic [WORD_W-1:0] mem [NODE_COUNT];
  logic [WORD_W-1:0] rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [ufws_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [NW-1:0]     node_a_r, node_a_nxt;
  logic [NW-1:0]     node_b_r, node_b_nxt;
  logic              weight_in_r, weight_in_nxt;
  logic              second_r, second_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     top_r, top_nxt;
  logic [RW-1:0]     top_rank_r, top_rank_nxt;
  logic [WW-1:0]     top_wt_r, top_wt_nxt;
  logic [IW-1:0]     ra_r, ra_nxt;
  logic [RW-1:0]     ra_rank_r, ra_rank_nxt;
  logic [WW-1:0]     ra_wt_r, ra_wt_nxt;
  logic [IW-1:0]     win_r, win_nxt;
  logic [RW-1:0]     win_rank_r, win_rank_nxt;
  logic [NW-1:0]     res_root_r, res_root_nxt;
  logic [WW-1:0]     res_weight_r, res_weight_nxt;
  logic              res_merged_r, res_merged_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NW-1:0]     out_root_r, out_root_nxt;
  logic [WW-1:0]     out_weight_r, out_weight_nxt;
  logic              out_merged_r, out_merged_nxt;

  // Index views of the node fields at the memory's width.
  logic [31:0]   in_a32, in_b32, na32, nb32, top32, cur32, up32, win32;
  logic [IW-1:0] in_a_idx, na_idx, nb_idx, start_idx;
  logic [IW-1:0] rd_par;
  logic [RW-1:0] rd_rank;
  logic [WW-1:0] rd_wt;
  logic          up_is_root;
  logic          in_fire;
  logic          out_free;
  logic          is_union;

  // Merge arithmetic.
  logic          rank_inc;
  logic [RW-1:0] ra_rank_new;
  logic          a_wins;
  logic [WW:0]   wsum;
  logic [WW-1:0] wsum_sat;

  assign in_a32    = 32'(in_node_a);
  assign in_b32    = 32'(in_node_b);
  assign na32      = 32'(node_a_r);
  assign nb32      = 32'(node_b_r);
  assign top32     = 32'(top_r);
  assign cur32     = 32'(cur_r);
  assign in_a_idx  = in_a32[IW-1:0];
  assign na_idx    = na32[IW-1:0];
  assign nb_idx    = nb32[IW-1:0];
  assign start_idx = second_r ? nb_idx : na_idx;

  assign rd_par  = rd_data_r[WORD_W-1 -: IW];
  assign rd_rank = rd_data_r[WW +: RW];
  assign rd_wt   = rd_data_r[WW-1:0];
  assign up32    = 32'(rd_par);

  // A parent entry outside the table ends the walk as if it were a root.
  assign up_is_root = (rd_par == cur_r) || (up32 >= NODE_COUNT);

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_union = (mode_r == ufws_pkg::MODE_UNION);

  assign rank_inc    = (ra_rank_r == top_rank_r) && (ra_rank_r != ufws_pkg::RANK_MAX);
  assign ra_rank_new = rank_inc ? ra_rank_r + RW'(1) : ra_rank_r;
  assign a_wins      = (ra_rank_new > top_rank_r);
  assign wsum        = {1'b0, ra_wt_r} + {1'b0, top_wt_r};
  assign wsum_sat    = wsum[WW] ? ufws_pkg::WEIGHT_MAX : wsum[WW-1:0];
  assign win32       = a_wins ? 32'(ra_r) : 32'(top_r);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    mode_nxt       = mode_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    weight_in_nxt  = weight_in_r;
    second_nxt     = second_r;
    cur_nxt        = cur_r;
    top_nxt        = top_r;
    top_rank_nxt   = top_rank_r;
    top_wt_nxt     = top_wt_r;
    ra_nxt         = ra_r;
    ra_rank_nxt    = ra_rank_r;
    ra_wt_nxt      = ra_wt_r;
    win_nxt        = win_r;
    win_rank_nxt   = win_rank_r;
    res_root_nxt   = res_root_r;
    res_weight_nxt = res_weight_r;
    res_merged_nxt = res_merged_r;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = {cur_r, {RW{1'b0}}, {WW{1'b0}}};

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = {clr_cnt_r, {RW{1'b0}}, {WW{1'b0}}};
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = in_a_idx;
        if (in_fire) begin
          mode_nxt       = in_mode;
          node_a_nxt     = in_node_a;
          node_b_nxt     = in_node_b;
          weight_in_nxt  = in_weight_in;
          second_nxt     = 1'b0;
          cur_nxt        = in_a_idx;
          res_merged_nxt = 1'b0;
          if ((in_a32 >= NODE_COUNT) ||
              ((in_mode == ufws_pkg::MODE_UNION) && (in_b32 >= NODE_COUNT))) begin
            res_root_nxt   = in_node_a;
            res_weight_nxt = '0;
            state_nxt      = S_OUT;
          end else if (in_mode == ufws_pkg::MODE_LOAD) begin
            state_nxt = S_LDCHK;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_LDCHK: begin
        // Keep the node's word on the read port in case the walk continues.
        rd_addr = cur_r;
        if ((rd_par == cur_r) && (rd_rank == '0)) begin
          wr_en          = 1'b1;
          wr_addr        = cur_r;
          wr_data        = {cur_r, {RW{1'b0}}, WW'(weight_in_r)};
          res_root_nxt   = node_a_r;
          res_weight_nxt = WW'(weight_in_r);
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!up_is_root) begin
          rd_addr = rd_par;
          cur_nxt = rd_par;
        end else begin
          top_nxt      = cur_r;
          top_rank_nxt = rd_rank;
          top_wt_nxt   = rd_wt;
          if (start_idx == cur_r) begin
            state_nxt = S_FDONE;
          end else begin
            rd_addr   = start_idx;
            cur_nxt   = start_idx;
            state_nxt = S_COMP;
          end
        end
      end
      S_COMP: begin
        // Point the node at the root and move on to its old parent.
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = {top_r, rd_rank, rd_wt};
        if ((rd_par == top_r) || (up32 >= NODE_COUNT)) begin
          state_nxt = S_FDONE;
        end else begin
          rd_addr = rd_par;
          cur_nxt = rd_par;
        end
      end
      S_FDONE: begin
        if (is_union && !second_r) begin
          ra_nxt      = top_r;
          ra_rank_nxt = top_rank_r;
          ra_wt_nxt   = top_wt_r;
          second_nxt  = 1'b1;
          rd_addr     = nb_idx;
          cur_nxt     = nb_idx;
          state_nxt   = S_WALK;
        end else if (is_union && (ra_r != top_r)) begin
          state_nxt = S_MERGE1;
        end else begin
          res_root_nxt   = top32[NW-1:0];
          res_weight_nxt = top_wt_r;
          state_nxt      = S_OUT;
        end
      end
      S_MERGE1: begin
        // The loser points at the winner and gives up its weight.
        wr_en   = 1'b1;
        wr_addr = a_wins ? top_r : ra_r;
        wr_data = a_wins ? {ra_r, top_rank_r, {WW{1'b0}}}
                         : {top_r, ra_rank_r, {WW{1'b0}}};
        win_nxt        = win32[IW-1:0];
        win_rank_nxt   = a_wins ? ra_rank_new : top_rank_r;
        res_root_nxt   = win32[NW-1:0];
        res_weight_nxt = wsum_sat;
        res_merged_nxt = 1'b1;
        state_nxt      = S_MERGE2;
      end
      S_MERGE2: begin
        wr_en     = 1'b1;
        wr_addr   = win_r;
        wr_data   = {win_r, win_rank_r, res_weight_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_root_nxt   = out_root_r;
    out_weight_nxt = out_weight_r;
    out_merged_nxt = out_merged_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_root_nxt   = res_root_r;
      out_weight_nxt = res_weight_r;
      out_merged_nxt = res_merged_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    node_a_r     <= node_a_nxt;
    node_b_r     <= node_b_nxt;
    weight_in_r  <= weight_in_nxt;
    cur_r        <= cur_nxt;
    top_r        <= top_nxt;
    top_rank_r   <= top_rank_nxt;
    top_wt_r     <= top_wt_nxt;
    ra_r         <= ra_nxt;
    ra_rank_r    <= ra_rank_nxt;
    ra_wt_r      <= ra_wt_nxt;
    win_r        <= win_nxt;
    win_rank_r   <= win_rank_nxt;
    res_root_r   <= res_root_nxt;
    res_weight_r <= res_weight_nxt;
    res_merged_r <= res_merged_nxt;
    out_root_r   <= out_root_nxt;
    out_weight_r <= out_weight_nxt;
    out_merged_r <= out_merged_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_root       = out_root_r;
  assign out_set_weight = out_weight_r;
  assign out_merged     = out_merged_r;

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (cur32 < NODE_COUNT))
    else $error("walk reached a node outside the table");

  a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (cur_r != top_r))
    else $error("path compression rewrote the root");

  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE1) |-> (ra_r != top_r))
    else $error("merge started on a single set");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && !out_valid_r) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished result not moved to the output register");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!out_valid_r && in_stall))
    else $error("activity during the memory clearing sweep");

endmodule

@@ test/tb_union_find_weighted_sets_unit.sv @@
// Self-checking testbench for the weighted union-find unit with random handshake pacing.
`timescale 1ns / 100ps

module tb_union_find_weighted_sets_unit;

  localparam int NODES        = ufws_pkg::NODE_COUNT_DEF;
  localparam int MW           = ufws_pkg::MODE_W;
  localparam int NW           = ufws_pkg::NODE_W;
  localparam int RW           = ufws_pkg::RANK_W;
  localparam int WW           = ufws_pkg::WEIGHT_W;
  localparam int RANDOM_ITEMS = 530;
  localparam int QUIET_TAIL   = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    ufws_pkg::mode_t mode;
    logic [NW-1:0]   node_a;
    logic [NW-1:0]   node_b;
    logic            weight_in;
  } set_op_t;

  typedef struct packed {
    logic [NW-1:0] root;
    logic [WW-1:0] weight;
    logic          merged;
  } set_result_t;

  typedef struct {
    set_op_t     op;
    bit          typed;
    set_result_t res;
  } dir_row_t;

  logic          clk;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_stall;
  logic [MW-1:0] in_mode        = '0;
  logic [NW-1:0] in_node_a      = '0;
  logic [NW-1:0] in_node_b      = '0;
  logic          in_weight_in   = 1'b0;
  logic          out_valid;
  logic          out_stall      = 1'b0;
  logic [NW-1:0] out_root;
  logic [WW-1:0] out_set_weight;
  logic          out_merged;

  // Shadow copy of the node memory.
  logic [NW-1:0] shadow_parent [NODES];
  logic [RW-1:0] shadow_rank   [NODES];
  logic [WW-1:0] shadow_weight [NODES];

  set_result_t   pending_results [$];
  dir_row_t      dir_rows [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   rx_idle_pct    = 0;

  union_find_weighted_sets_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_node_a      (in_node_a),
    .in_node_b      (in_node_b),
    .in_weight_in   (in_weight_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_root       (out_root),
    .out_set_weight (out_set_weight),
    .out_merged     (out_merged)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Root lookup that rewrites every node on the walked path to point at the root.
  function automatic logic [NW-1:0] locate_root(input logic [NW-1:0] node);
    logic [NW-1:0] top;
    logic [NW-1:0] walk;
    logic [NW-1:0] up;
    top = node;
    while (shadow_parent[top] != top) top = shadow_parent[top];
    walk = node;
    while (walk != top) begin
      up = shadow_parent[walk];
      shadow_parent[walk] = top;
      walk = up;
    end
    return top;
  endfunction

  function automatic set_result_t predict_set_op(input set_op_t op);
    set_result_t   r;
    logic [NW-1:0] ra;
    logic [NW-1:0] rb;
    logic [NW-1:0] winner;
    logic [NW-1:0] loser;
    logic [WW:0]   sum;
    r.merged = 1'b0;
    case (op.mode)
      ufws_pkg::MODE_LOAD: begin
        if (shadow_parent[op.node_a] == op.node_a && shadow_rank[op.node_a] == '0)
          shadow_weight[op.node_a] = WW'(op.weight_in);
        r.root = locate_root(op.node_a);
      end
      ufws_pkg::MODE_UNION: begin
        ra = locate_root(op.node_a);
        rb = locate_root(op.node_b);
        r.root = ra;
        if (ra != rb) begin
          r.merged = 1'b1;
          if (shadow_rank[ra] == shadow_rank[rb] && shadow_rank[ra] != ufws_pkg::RANK_MAX)
            shadow_rank[ra] = shadow_rank[ra] + RW'(1);
          if (shadow_rank[ra] > shadow_rank[rb]) begin
            winner = ra;
            loser  = rb;
          end else begin
            winner = rb;
            loser  = ra;
          end
          sum = {1'b0, shadow_weight[winner]} + {1'b0, shadow_weight[loser]};
          if (sum > {1'b0, ufws_pkg::WEIGHT_MAX}) sum = {1'b0, ufws_pkg::WEIGHT_MAX};
          shadow_parent[loser]  = winner;
          shadow_weight[winner] = sum[WW-1:0];
          shadow_weight[loser]  = '0;
          r.root = winner;
        end
      end
      default: r.root = locate_root(op.node_a);
    endcase
    r.weight = shadow_weight[r.root];
    return r;
  endfunction

  function automatic void add_row(input ufws_pkg::mode_t m, input int a, input int b,
                                  input bit w, input bit typed, input int root,
                                  input int wt, input bit mg);
    dir_row_t row;
    row.op    = '{mode: m, node_a: NW'(a), node_b: NW'(b), weight_in: w};
    row.typed = typed;
    row.res   = '{root: NW'(root), weight: WW'(wt), merged: mg};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [NW-1:0] pick_node(input int base, input int span);
    if ($urandom_range(0, 99) < 85) return NW'(base + $urandom_range(0, span - 1));
    return NW'($urandom_range(0, NODES - 1));
  endfunction

  // Presents one item and returns at the edge where its transfer happens.
  task automatic drive_item(input set_op_t op);
    in_valid     <= 1'b1;
    in_mode      <= op.mode;
    in_node_a    <= op.node_a;
    in_node_b    <= op.node_b;
    in_weight_in <= op.weight_in;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic maybe_gap(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Receiver pacing: random stall bursts at the current rate.
  initial begin : rx_pacing
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    set_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("%0t: unexpected result root=%0d weight=%0d merged=%0b",
                   $realtime, out_root, out_set_weight, out_merged);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_root !== exp_res.root || out_set_weight !== exp_res.weight ||
            out_merged !== exp_res.merged) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("%0t: mismatch root %0d/%0d weight %0d/%0d merged %0b/%0b (exp/got)",
                     $realtime, exp_res.root, out_root, exp_res.weight, out_set_weight,
                     exp_res.merged, out_merged);
        end
      end
    end
  end

  initial begin : stimulus
    set_op_t     op;
    set_result_t res;
    int          sent;
    int          base;
    int          span;
    int          seg_left;
    int unsigned tx_idle_pct;
    int unsigned pick;

    for (int i = 0; i < NODES; i++) begin
      shadow_parent[i] = NW'(i);
      shadow_rank[i]   = '0;
      shadow_weight[i] = '0;
    end

    // Fresh nodes, extreme indexes, reloads of a singleton, merges of equal and
    // unequal ranks, repeated and self unions, loads on nodes that are not
    // singletons, the spare mode code, and finds over paths worth compressing.
    add_row(ufws_pkg::MODE_FIND,  0,    0,    1'b0, 1'b1, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_FIND,  1023, 1023, 1'b1, 1'b1, 1023, 0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  1023, 0,    1'b1, 1'b1, 1023, 1, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  0,    1023, 1'b1, 1'b1, 0,    1, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  0,    0,    1'b0, 1'b1, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  0,    0,    1'b1, 1'b1, 0,    1, 1'b0);
    add_row(ufws_pkg::MODE_ALT,   512,  0,    1'b1, 1'b1, 512,  0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 0,    1023, 1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 1023, 0,    1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  1023, 0,    1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  0,    0,    1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_ALT,   1023, 1023, 1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_FIND,  1023, 0,    1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  682,  341,  1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  341,  682,  1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 682,  341,  1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 341,  0,    1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 5,    5,    1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 6,    682,  1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_FIND,  1023, 341,  1'b0, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_ALT,   341,  6,    1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_UNION, 1023, 1023, 1'b1, 1'b0, 0,    0, 1'b0);
    add_row(ufws_pkg::MODE_LOAD,  6,    0,    1'b1, 1'b0, 0,    0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    rx_idle_pct = 30;
    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].op);
      res = predict_set_op(dir_rows[i].op);
      pending_results.insert(pending_results.size(), dir_rows[i].typed ? dir_rows[i].res : res);
      maybe_gap(30);
    end

    // Hold the sender until the unit has handed back everything.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);

    // Random traffic in segments, each working mostly inside a window of nodes so
    // that sets grow, get merged and get walked.
    sent     = 0;
    seg_left = 0;
    base     = 0;
    span     = 8;
    tx_idle_pct = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        span     = $urandom_range(4, 64);
        base     = $urandom_range(0, NODES - span);
        case ($urandom_range(0, 2))
          0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
          1:       begin tx_idle_pct = 15; rx_idle_pct = 15; end
          default: begin tx_idle_pct = 40; rx_idle_pct = 40; end
        endcase
      end
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25)      op.mode = ufws_pkg::MODE_LOAD;
      else if (pick < 60) op.mode = ufws_pkg::MODE_UNION;
      else if (pick < 88) op.mode = ufws_pkg::MODE_FIND;
      else                op.mode = ufws_pkg::MODE_ALT;
      op.node_a    = pick_node(base, span);
      op.node_b    = pick_node(base, span);
      op.weight_in = 1'($urandom_range(0, 1));
      drive_item(op);
      pending_results.insert(pending_results.size(), predict_set_op(op));
      maybe_gap(tx_idle_pct);
      sent++;
      seg_left--;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ufws_pkg.sv
hw/rtl/union_find_weighted_sets.sv
test/tb_union_find_weighted_sets_unit.sv
